/* sv/ddsq_pkg.sv */
`timescale 1ns / 1ps
package ddsq_pkg;

  // default fraction width of the internal fixed point
  localparam int unsigned DDSQ_FRAC_BITS = 16;

  // pi as a 32-bit fraction constant
  localparam logic [63:0] PI_Q32 = 64'd13493037705;

  // sine polynomial, nested form, innermost divisor first
  localparam int unsigned POLY_TERMS = 5;
  localparam int unsigned POLY_DIV [POLY_TERMS] = '{110, 72, 42, 20, 6};

  // sine unit depth: fold, pi product, squaring, three per term, final product
  localparam int unsigned SIN_LAT = 3 + 3 * POLY_TERMS + 1;

  // dimming law codes
  localparam logic [1:0] LAW_LINEAR = 2'd0;
  localparam logic [1:0] LAW_SQRT   = 2'd1;
  localparam logic [1:0] LAW_TRIAC  = 2'd2;

  // register index (address bit 2)
  localparam logic REG_LAW  = 1'b0;
  localparam logic REG_MEAN = 1'b1;

  // io limits
  localparam logic [16:0] LEVEL_FULL = 17'd65536;
  localparam logic [17:0] OUT_MAX    = 18'd131072;

endpackage

/* sv/ddsq_sin_pi.sv */
`timescale 1ns / 1ps
module ddsq_sin_pi import ddsq_pkg::*; #(
  parameter int unsigned FRAC_BITS = DDSQ_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [FRAC_BITS:0]   x,
  output logic                 out_valid,
  output logic [FRAC_BITS:0]   s
);

  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned PW = 2 * F + 2;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
  localparam logic [63:0] HALF = 64'd1 << (F - 1);
  localparam logic [F+1:0] PI = (F + 2)'((PI_Q32 + (64'd1 << (31 - F))) >> (32 - F));

  // clamp to one and fold about one half
  logic [F:0]   xc;
  logic [F:0]   xr;
  logic [F-1:0] xf;
  always_comb begin
    xc = (x > ONE) ? ONE : x;
    xr = ONE - xc;
    xf = (xr < xc) ? xr[F-1:0] : xc[F-1:0];
  end

  logic         v0;
  logic [F-1:0] x0;
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= in_valid;
    end
    x0 <= xf;
  end

  // u = pi * x
  logic [PW-1:0] pu;
  assign pu = PW'(PI) * PW'(x0) + PW'(HALF);

  logic       v1;
  logic [F:0] u1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    u1 <= pu[2*F:F];
  end

  // u squared
  logic [PW-1:0] pu2;
  assign pu2 = PW'(u1) * PW'(u1) + PW'(HALF);

  logic         v2;
  logic [F:0]   u2r;
  logic [F+1:0] usq2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    u2r  <= u1;
    usq2 <= pu2[2*F+1:F];
  end

  // term chain, index 0 enters the innermost term
  logic         v_ch  [0:POLY_TERMS];
  logic [F:0]   u_ch  [0:POLY_TERMS];
  logic [F+1:0] u2_ch [0:POLY_TERMS];
  logic [F:0]   t_ch  [0:POLY_TERMS];

  assign v_ch[0]  = v2;
  assign u_ch[0]  = u2r;
  assign u2_ch[0] = usq2;
  assign t_ch[0]  = ONE;

  for (genvar k = 0; k < POLY_TERMS; k++) begin : g_term
    localparam int unsigned DIV = POLY_DIV[k];
    localparam logic [63:0] RECIP_W = (64'd1 << (F + 3)) / DIV;
    localparam logic [F:0] RECIP = RECIP_W[F:0];
    localparam logic [F+2:0] DIV_HALF = (F + 3)'(DIV / 2);
    localparam logic [F+2:0] DIV_W = (F + 3)'(DIV);

    // stage a: u2 * t
    logic [2*F+2:0] pm;
    assign pm = (2 * F + 3)'(u2_ch[k]) * (2 * F + 3)'(t_ch[k]) + (2 * F + 3)'(HALF);

    logic         va;
    logic [F+1:0] ma;
    logic [F:0]   ua;
    logic [F+1:0] u2a;
    always_ff @(posedge clk) begin
      if (rst) begin
        va <= 1'b0;
      end else begin
        va <= v_ch[k];
      end
      ma  <= pm[2*F+1:F];
      ua  <= u_ch[k];
      u2a <= u2_ch[k];
    end

    // stage b: quotient estimate by reciprocal, low by at most one
    logic [F+2:0]   ap;
    logic [2*F+3:0] pq;
    assign ap = (F + 3)'(ma) + DIV_HALF;
    assign pq = (2 * F + 4)'(ap) * (2 * F + 4)'(RECIP);

    logic         vb;
    logic [F+2:0] apb;
    logic [F:0]   q0b;
    logic [F:0]   ub;
    logic [F+1:0] u2b;
    always_ff @(posedge clk) begin
      if (rst) begin
        vb <= 1'b0;
      end else begin
        vb <= va;
      end
      apb <= ap;
      q0b <= pq[2*F+3:F+3];
      ub  <= ua;
      u2b <= u2a;
    end

    // stage c: remainder correction, then t = 1 - p floored at 0
    logic [F+2:0] rm;
    logic [F+1:0] pp;
    logic [F:0]   tn;
    always_comb begin
      rm = apb - (F + 3)'((F + 3)'(q0b) * DIV_W);
      pp = (F + 2)'(q0b) + (F + 2)'(rm >= DIV_W);
      tn = (pp > (F + 2)'(ONE)) ? '0 : ONE - pp[F:0];
    end

    logic         vc;
    logic [F:0]   tc;
    logic [F:0]   uc;
    logic [F+1:0] u2c;
    always_ff @(posedge clk) begin
      if (rst) begin
        vc <= 1'b0;
      end else begin
        vc <= vb;
      end
      tc  <= tn;
      uc  <= ub;
      u2c <= u2b;
    end

    assign v_ch[k+1]  = vc;
    assign u_ch[k+1]  = uc;
    assign u2_ch[k+1] = u2c;
    assign t_ch[k+1]  = tc;
  end

  // s = u * t capped at one
  logic [PW-1:0] ps;
  logic [F+1:0]  sf;
  always_comb begin
    ps = PW'(u_ch[POLY_TERMS]) * PW'(t_ch[POLY_TERMS]) + PW'(HALF);
    sf = ps[2*F+1:F];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v_ch[POLY_TERMS];
    end
    s <= (sf > (F + 2)'(ONE)) ? ONE : sf[F:0];
  end

endmodule

/* sv/dimmer_drive_squared.sv */
`timescale 1ns / 1ps
// Squared drive voltage of a phase-cut dimmer, normalized so that an undimmed
// mains cycle averages 1.0 (output Q2.16). A transaction is taken at every
// clock edge with start high; busy stays low, so one item enters per cycle.
// The result shows on drive_squared with done high for one cycle and must be
// taken then: there is no way to stall the output. The latency is the same
// at any FRAC_BITS and is set by the sine polynomial (three stages per term)
// and by the rounding divide by two pi of the triac mean, a reciprocal product
// followed by one correction stage; all modes share the same pipeline and
// latency. Set dimming_law and mean_mode over the register port only while no
// item is in flight.
module dimmer_drive_squared import ddsq_pkg::*; #(
  parameter int unsigned FRAC_BITS = DDSQ_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] mains_phase,
  input  logic [16:0] dim_level,
  output logic        done,
  output logic [17:0] drive_squared,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned PW  = 2 * F + 2;
  localparam int unsigned RW  = 2 * F + 1;
  localparam int unsigned QB  = F - 2;
  localparam int unsigned LAT = SIN_LAT + 5;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
  localparam logic [63:0] HALF = 64'd1 << (F - 1);
  localparam logic [63:0] TP_W = ((PI_Q32 << 1) + (64'd1 << (31 - F))) >> (32 - F);
  localparam logic [F+2:0] TP = TP_W[F+2:0];
  localparam logic [F+2:0] TP_HALF = TP >> 1;
  localparam logic [63:0] RTP_W = (64'd1 << RW) / TP_W;
  localparam logic [F-1:0] RTP = RTP_W[F-1:0];

  typedef struct packed {
    logic [F:0] a2;
    logic [F:0] lvl;
    logic       zero;
    logic       neg;
    logic       tm;
    logic       mean;
  } side_t;

  // configuration registers
  logic [1:0] law;
  logic       mean;

  always_ff @(posedge clk) begin
    if (rst) begin
      law  <= LAW_LINEAR;
      mean <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_LAW:  law  <= pwdata[1:0];
        REG_MEAN: mean <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LAW:  prdata = {30'd0, law};
      REG_MEAN: prdata = {31'd0, mean};
      default:  prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign busy   = 1'b0;

  // input rescale to the internal fraction width
  logic [16:0] dim_c;
  logic [15:0] half_io;
  logic [F:0]  lvl_in;
  logic [F:0]  half_in;

  assign dim_c   = (dim_level > LEVEL_FULL) ? LEVEL_FULL : dim_level;
  assign half_io = {mains_phase[14:0], 1'b0};

  if (F >= 16) begin : g_in_up
    assign lvl_in  = (F + 1)'(dim_c) << (F - 16);
    assign half_in = (F + 1)'(half_io) << (F - 16);
  end else begin : g_in_dn
    localparam int unsigned SH = 16 - F;
    assign lvl_in  = (F + 1)'((18'(dim_c) + 18'(1 << (SH - 1))) >> SH);
    assign half_in = (F + 1)'((17'(half_io) + 17'(1 << (SH - 1))) >> SH);
  end

  // amplitude squared, gate and sine argument
  logic [PW-1:0] pa;
  logic [F:0]    a2_in;
  logic [F:0]    gate;
  logic          triac;
  logic [F+1:0]  y2;
  logic [F:0]    y;
  logic          neg_in;
  logic [F:0]    x_in;

  always_comb begin
    pa     = PW'(lvl_in) * PW'(lvl_in) + PW'(HALF);
    triac  = 1'b0;
    case (law)
      LAW_SQRT: begin
        a2_in = lvl_in;
        gate  = '0;
      end
      LAW_TRIAC: begin
        a2_in = ONE;
        gate  = ONE - lvl_in;
        triac = 1'b1;
      end
      LAW_LINEAR: begin
        a2_in = pa[2*F:F];
        gate  = '0;
      end
      default: begin
        a2_in = pa[2*F:F];
        gate  = '0;
      end
    endcase
    y2 = {gate, 1'b0};
    if (y2 > (F + 2)'(ONE)) begin
      y      = (F + 1)'(y2 - (F + 2)'(ONE));
      neg_in = 1'b1;
    end else begin
      y      = y2[F:0];
      neg_in = 1'b0;
    end
    x_in = (mean && triac) ? y : half_in;
  end

  // stage a
  logic  va;
  logic [F:0] xa;
  side_t side_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= start && !busy;
    end
    xa          <= x_in;
    side_a.a2   <= a2_in;
    side_a.lvl  <= lvl_in;
    side_a.zero <= half_in < gate;
    side_a.neg  <= neg_in;
    side_a.tm   <= mean && triac;
    side_a.mean <= mean;
  end

  // shared sine unit
  logic       vs;
  logic [F:0] s_s;

  ddsq_sin_pi #(
    .FRAC_BITS(FRAC_BITS)
  ) u_sin (
    .clk      (clk),
    .rst      (rst),
    .in_valid (va),
    .x        (xa),
    .out_valid(vs),
    .s        (s_s)
  );

  // side data delay matched to the sine unit
  side_t side_q [SIN_LAT];
  always_ff @(posedge clk) begin
    side_q[0] <= side_a;
    for (int i = 1; i < SIN_LAT; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // stage b: s squared and divider numerator
  logic [PW-1:0] pss;
  assign pss = PW'(s_s) * PW'(s_s) + PW'(HALF);

  logic          vb;
  logic [F:0]    ssb;
  logic [RW-1:0] remb;
  side_t         sideb;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= vs;
    end
    ssb   <= pss[2*F:F];
    remb  <= (RW'(s_s) << F) + RW'(TP_HALF);
    sideb <= side_q[SIN_LAT-1];
  end

  // sample value or plain mean
  logic [PW-1:0] pv;
  logic [F+1:0]  vsel0;
  always_comb begin
    pv = PW'(sideb.a2) * PW'(ssb) + PW'(HALF);
    if (sideb.mean) begin
      vsel0 = (F + 2)'(sideb.a2);
    end else if (sideb.zero) begin
      vsel0 = '0;
    end else begin
      vsel0 = {pv[2*F:F], 1'b0};
    end
  end

  // stage c: quotient estimate by reciprocal of two pi, low by at most one
  logic [3*F:0] pr;
  assign pr = (3 * F + 1)'(remb) * (3 * F + 1)'(RTP);

  logic          vc;
  logic [RW-1:0] remc;
  logic [QB-1:0] q0c;
  logic [F+1:0]  vselc;
  logic [F:0]    lvlc;
  logic          negc;
  logic          tmc;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else begin
      vc <= vb;
    end
    remc  <= remb;
    q0c   <= pr[RW+QB-1:RW];
    vselc <= vsel0;
    lvlc  <= sideb.lvl;
    negc  <= sideb.neg;
    tmc   <= sideb.tm;
  end

  // stage d: remainder correction of the quotient
  logic [RW-1:0] rmc;
  logic [QB-1:0] qn;
  always_comb begin
    rmc = remc - RW'(RW'(q0c) * RW'(TP));
    qn  = q0c + QB'(rmc >= RW'(TP));
  end

  logic          vd;
  logic [QB-1:0] quod;
  logic [F+1:0]  vseld;
  logic [F:0]    lvld;
  logic          negd;
  logic          tmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else begin
      vd <= vc;
    end
    quod  <= qn;
    vseld <= vselc;
    lvld  <= lvlc;
    negd  <= negc;
    tmd   <= tmc;
  end

  // triac mean, then rescale to Q.16 and clamp
  logic [F+1:0] qx;
  logic [F+1:0] lx;
  logic [F+1:0] vf;
  logic [18:0]  vr;

  always_comb begin
    qx = (F + 2)'(quod);
    lx = (F + 2)'(lvld);
    if (!tmd) begin
      vf = vseld;
    end else if (negd) begin
      vf = (qx > lx) ? '0 : lx - qx;
    end else begin
      vf = lx + qx;
    end
  end

  if (F > 16) begin : g_out_dn
    localparam int unsigned SH = F - 16;
    logic [F+2:0] vt;
    assign vt = (F + 3)'(vf) + (F + 3)'(64'd1 << (SH - 1));
    assign vr = 19'(vt >> SH);
  end else begin : g_out_up
    assign vr = 19'(vf) << (16 - F);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vd;
    end
    drive_squared <= (vr > 19'(OUT_MAX)) ? OUT_MAX : vr[17:0];
  end

  // every accepted transaction gives one result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("result missing after accepted transaction");

  // no result without a transaction accepted that many cycles earlier
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without matching transaction");

  // result stays within the Q2.16 range
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (drive_squared <= OUT_MAX))
    else $error("drive_squared above 2.0");

endmodule

/* tb/dimmer_drive_squared_checker.sv */
`timescale 1ns / 1ps
module dimmer_drive_squared_checker import ddsq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] mains_phase,
  input  logic [16:0] dim_level,
  input  logic        done,
  input  logic [17:0] drive_squared,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);

  localparam logic [63:0] ONE  = 64'd65536;
  localparam logic [63:0] HALF = 64'd32768;

  logic [1:0]  law_reg;
  logic        mean_reg;
  logic [17:0] drive_queue [$];

  function automatic logic [63:0] mul_round(logic [63:0] a, logic [63:0] b);
    return (a * b + HALF) >> 16;
  endfunction

  function automatic logic [63:0] div_round(logic [63:0] a, logic [63:0] d);
    return (a + d / 2) / d;
  endfunction

  function automatic logic [63:0] pi_frac(int k);
    return (PI_Q32 * k + 64'd32768) >> 16;
  endfunction

  // sine of pi*x, folded about one half, nested polynomial
  function automatic logic [63:0] sine_of_pi(logic [63:0] x);
    logic [63:0] u, u2, t, p, s;
    t = ONE;
    if (x > ONE) x = ONE;
    if (ONE - x < x) x = ONE - x;
    u  = mul_round(pi_frac(1), x);
    u2 = mul_round(u, u);
    for (int k = 0; k < POLY_TERMS; k++) begin
      p = div_round(mul_round(u2, t), POLY_DIV[k]);
      t = (p > ONE) ? 64'd0 : ONE - p;
    end
    s = mul_round(u, t);
    return (s > ONE) ? ONE : s;
  endfunction

  function automatic logic [17:0] drive_of(logic [15:0] phase, logic [16:0] dim);
    logic [63:0] lvl, a2, gate, v, y, q, half, s, twopi;
    logic        neg;
    gate = 0;
    neg  = 1'b0;
    lvl  = (dim > LEVEL_FULL) ? 64'(LEVEL_FULL) : 64'(dim);
    if (law_reg == LAW_SQRT) begin
      a2 = lvl;
    end else if (law_reg == LAW_TRIAC) begin
      a2   = ONE;
      gate = ONE - lvl;
    end else begin
      a2 = mul_round(lvl, lvl);
    end
    if (mean_reg) begin
      if (law_reg == LAW_TRIAC) begin
        y = gate * 2;
        twopi = pi_frac(2);
        if (y > ONE) begin
          y   = y - ONE;
          neg = 1'b1;
        end
        q = (sine_of_pi(y) * ONE + twopi / 2) / twopi;
        if (neg) v = (q > lvl) ? 64'd0 : lvl - q;
        else v = lvl + q;
      end else begin
        v = a2;
      end
    end else begin
      half = 64'({phase[14:0], 1'b0});
      if (half < gate) begin
        v = 0;
      end else begin
        s = sine_of_pi(half);
        v = mul_round(a2, mul_round(s, s)) * 2;
      end
    end
    if (v > 64'(OUT_MAX)) v = 64'(OUT_MAX);
    return v[17:0];
  endfunction

  // register shadow, prediction and compare
  always @(posedge clk) begin
    if (rst) begin
      law_reg    <= LAW_LINEAR;
      mean_reg   <= 1'b0;
      fail_count <= 0;
      pending    <= 0;
      drive_queue.delete();
    end else begin
      if (done) begin
        if (drive_queue.size() == 0) begin
          $display("%0t: unexpected result drive_squared=%0d", $time, drive_squared);
          fail_count <= fail_count + 1;
        end else begin
          logic [17:0] exp_drive;
          exp_drive = drive_queue.pop_front();
          if (exp_drive !== drive_squared) begin
            $display("%0t: drive_squared expected %0d actual %0d",
                     $time, exp_drive, drive_squared);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) drive_queue.push_back(drive_of(mains_phase, dim_level));
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_LAW) law_reg <= pwdata[1:0];
        else mean_reg <= pwdata[0];
      end
      pending <= drive_queue.size();
    end
  end

endmodule

/* tb/dimmer_drive_squared_test.sv */
`timescale 1ns / 1ps
module dimmer_drive_squared_test import ddsq_pkg::*;;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] mains_phase = '0;
  logic [16:0] dim_level = '0;
  logic        done;
  logic [17:0] drive_squared;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          idle_pct;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dimmer_drive_squared dut (.*);

  dimmer_drive_squared_checker checker_i (.*);

  // register write over the apb port
  task automatic write_reg(logic idx, logic [31:0] value);
    @(posedge clk);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one transaction, with random idle cycles ahead of it
  task automatic send_item(logic [15:0] phase, logic [16:0] dim);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    mains_phase <= phase;
    dim_level   <= dim;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // drain, then let the pipeline go quiet before touching registers
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [16:0] rand_level();
    case ($urandom_range(9))
      0: return 17'd0;
      1: return LEVEL_FULL;
      2: return 17'(65536 + $urandom_range(65535));
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  logic [15:0] phases [6] = '{16'd0, 16'd16384, 16'd32767, 16'd32768, 16'd49152, 16'hFFFF};
  logic [16:0] levels [4] = '{17'd0, 17'd32768, 17'd65536, 17'h1FFFF};

  initial begin
    idle_pct = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // directed: every law (unused code too) in both modes over edge values
    for (int law = 0; law < 4; law++) begin
      for (int m = 0; m < 2; m++) begin
        write_reg(REG_LAW, 32'(law));
        write_reg(REG_MEAN, 32'(m) | 32'hFFFF_FFFE * m);
        for (int i = 0; i < 3; i++) send_item(phases[$urandom_range(5)], levels[i + m]);
        drain();
      end
    end
    // random phases with changing settings and idle profiles
    for (int ph = 0; ph < 12; ph++) begin
      idle_pct = (ph < 4) ? 23 : (ph < 8) ? 70 : 0;
      write_reg(REG_LAW, $urandom_range(3) | ($urandom << 2));
      write_reg(REG_MEAN, $urandom);
      for (int i = 0; i < 42; i++) send_item(16'($urandom), rand_level());
      drain();
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* sim.f */
sv/ddsq_pkg.sv
sv/ddsq_sin_pi.sv
sv/dimmer_drive_squared.sv
tb/dimmer_drive_squared_checker.sv
tb/dimmer_drive_squared_test.sv
